FILE: design/can_message_segmenter_with_retry_top_assert.svh
// Assertion macros shared by the CAN message segmenter modules.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef CAN_MESSAGE_SEGMENTER_WITH_RETRY_TOP_ASSERT_SVH
`define CAN_MESSAGE_SEGMENTER_WITH_RETRY_TOP_ASSERT_SVH

// cons must hold in the same cycle as ante
`define CMS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cms: same-cycle check failed");

// cons must hold in the cycle after ante
`define CMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cms: next-cycle check failed");

`endif

FILE: design/cms_pkg.sv
// Shared constants, codes and types of the CAN message segmenter.
// No dependencies; used by the interfaces and all modules.
package cms_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int MSG_BYTES   = 256;
    localparam int ADDR_W      = $clog2(MSG_BYTES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int STEP_W      = ($clog2(FRAME_BYTES + 1) > 2) ? $clog2(FRAME_BYTES + 1) : 2;

    // word field widths
    localparam int OP_W      = 3;
    localparam int IDX_W     = 8;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 9;
    localparam int POS_W     = 2;
    localparam int NUM_W     = 8;
    localparam int DLEN_W    = 4;
    localparam int PAYLOAD_W = 64;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int LOAD_CMD_W = 16;
    localparam int DELAY_W    = 8;
    localparam int RETRY_W    = 8;
    localparam int RETRY_DELAY_RST = 10;
    localparam int MAX_RETRIES_RST = 1;

    // message layout
    localparam int MSG_CNT_W    = 32;
    localparam int STAMP_BYTES  = 4;
    localparam int STAMP_SEL_W  = $clog2(STAMP_BYTES);
    localparam int STAMP_ADDR   = 2;
    localparam int TYPE_LO_ADDR = 9;
    localparam int TYPE_HI_ADDR = 10;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 3'd0,
        OP_SUBMIT = 3'd1,
        OP_TICK   = 3'd2,
        OP_ACK    = 3'd3,
        OP_XMIT   = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOAD_CMD_TYPE = 2'd0,
        CFG_RETRY_DELAY   = 2'd1,
        CFG_MAX_RETRIES   = 2'd2
    } t_cfg_reg;

    typedef enum logic [POS_W-1:0] {
        POS_SINGLE = 2'd0,
        POS_FIRST  = 2'd1,
        POS_MIDDLE = 2'd2,
        POS_FINAL  = 2'd3
    } t_pos;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_TYPE_LO,
        S_TYPE_HI,
        S_TYPE_CMP,
        S_STAMP,
        S_GATHER,
        S_OUT
    } t_state;

    typedef struct packed {
        logic latch_item;
        logic item_wr;
        logic tick;
        logic ack;
        logic rd_lo;
        logic rd_hi;
        logic submit_apply;
        logic finish_apply;
        logic stamp_wr;
        logic frame_setup;
        logic gather;
        logic step_clr;
        logic step_inc;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              busy;
        logic              type_match;
        logic              frame_fin;
        logic [STEP_W-1:0] step;
        logic              out_free;
    } t_dp_sts;

endpackage

FILE: design/cms_if.sv
// Valid/ready channel interfaces for the segmenter input and result words.
// Depends on cms_pkg for field widths.
interface cms_in_if;
    import cms_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [IDX_W-1:0]    byte_index;
    logic [BYTE_W-1:0]   byte_value;
    logic [LEN_W-1:0]    msg_length;

    modport source (output valid, output op, output byte_index, output byte_value,
                    output msg_length, input ready);
    modport sink   (input valid, input op, input byte_index, input byte_value,
                    input msg_length, output ready);
endinterface

interface cms_out_if;
    import cms_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [POS_W-1:0]     seg_position;
    logic [NUM_W-1:0]     seg_number;
    logic [DLEN_W-1:0]    data_length;
    logic [PAYLOAD_W-1:0] payload;

    modport source (output valid, output seg_position, output seg_number,
                    output data_length, output payload, input ready);
    modport sink   (input valid, input seg_position, input seg_number,
                    input data_length, input payload, output ready);
endinterface

FILE: design/cms_ctrl.sv
// Sequencer of the segmenter: one input word at a time through the datapath.
// Depends on cms_pkg and the assertion macro header.
`include "can_message_segmenter_with_retry_top_assert.svh"

module cms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cms_pkg::t_dp_sts  i_sts,
    output cms_pkg::t_dp_cmd  o_cmd
);
    import cms_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.latch_item = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_IDLE;
                case (i_sts.op)
                    OP_WRITE: begin
                        o_cmd.item_wr = !i_sts.busy;
                    end
                    OP_SUBMIT: begin
                        if (!i_sts.busy) begin
                            n_state = S_TYPE_LO;
                        end
                    end
                    OP_TICK: begin
                        o_cmd.tick = 1'b1;
                    end
                    OP_ACK: begin
                        o_cmd.ack = 1'b1;
                    end
                    OP_XMIT: begin
                        if (i_sts.busy) begin
                            o_cmd.frame_setup = 1'b1;
                            o_cmd.step_clr    = 1'b1;
                            n_state           = S_GATHER;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_TYPE_LO: begin
                o_cmd.rd_lo = 1'b1;
                n_state     = S_TYPE_HI;
            end
            S_TYPE_HI: begin
                o_cmd.rd_hi = 1'b1;
                n_state     = S_TYPE_CMP;
            end
            S_TYPE_CMP: begin
                // message type high byte is now on the read port, low byte in r_type_lo; shared by submit and frame end
                if (i_sts.op == OP_SUBMIT) begin
                    o_cmd.submit_apply = 1'b1;
                    o_cmd.step_clr     = 1'b1;
                    n_state            = i_sts.type_match ? S_STAMP : S_IDLE;
                end else begin
                    o_cmd.finish_apply = 1'b1;
                    n_state            = S_OUT;
                end
            end
            S_STAMP: begin
                o_cmd.stamp_wr = 1'b1;
                o_cmd.step_inc = 1'b1;
                if (i_sts.step == STEP_W'(STAMP_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_GATHER: begin
                o_cmd.gather   = 1'b1;
                o_cmd.step_inc = 1'b1;
                if (i_sts.step == STEP_W'(FRAME_BYTES)) begin
                    n_state = i_sts.frame_fin ? S_TYPE_LO : S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `CMS_ASSERT_SAME(a_cmp_op, r_state == S_TYPE_CMP, i_sts.op == OP_SUBMIT || i_sts.op == OP_XMIT)
    `CMS_ASSERT_NEXT(a_gather_exit, r_state == S_GATHER && i_sts.step == STEP_W'(FRAME_BYTES), r_state == S_TYPE_LO || r_state == S_OUT)
    `CMS_ASSERT_SAME(a_load_when_free, o_cmd.out_load, i_sts.out_free)

endmodule

FILE: design/cms_dpath.sv
// Datapath of the segmenter: message store, transmit state, retry timer, result register.
// Depends on cms_pkg and the assertion macro header.
`include "can_message_segmenter_with_retry_top_assert.svh"

module cms_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cms_pkg::t_dp_cmd               i_cmd,
    output cms_pkg::t_dp_sts               o_sts,
    input  logic [cms_pkg::OP_W-1:0]       i_op,
    input  logic [cms_pkg::IDX_W-1:0]      i_byte_index,
    input  logic [cms_pkg::BYTE_W-1:0]     i_byte_value,
    input  logic [cms_pkg::LEN_W-1:0]      i_msg_length,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [cms_pkg::POS_W-1:0]      o_seg_position,
    output logic [cms_pkg::NUM_W-1:0]      o_seg_number,
    output logic [cms_pkg::DLEN_W-1:0]     o_data_length,
    output logic [cms_pkg::PAYLOAD_W-1:0]  o_payload,
    input  logic                           i_cfg_we,
    input  logic [cms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cms_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cms_pkg::*;

    // latched input word
    logic [OP_W-1:0]      r_op;
    logic [IDX_W-1:0]     r_idx;
    logic [BYTE_W-1:0]    r_val;
    logic [LEN_W-1:0]     r_len;

    // configuration
    logic [LOAD_CMD_W-1:0] r_cfg_load_cmd_type;
    logic [DELAY_W-1:0]    r_cfg_retry_delay;
    logic [RETRY_W-1:0]    r_cfg_max_retries;

    // message store
    logic [BYTE_W-1:0]    r_mem [MSG_BYTES];
    logic [BYTE_W-1:0]    r_rd_data;
    logic [ADDR_W-1:0]    mem_addr;
    logic                 mem_we;
    logic [BYTE_W-1:0]    mem_wdata;

    // transmit and retry state
    logic [CNT_W-1:0]     r_total_length;
    logic [CNT_W-1:0]     r_bytes_sent;
    logic [NUM_W-1:0]     r_seg_cnt;
    logic                 r_start_pending;
    logic                 r_busy;
    logic [DELAY_W-1:0]   r_retry_timer;
    logic [RETRY_W-1:0]   r_retry_count;
    logic [MSG_CNT_W-1:0] r_msg_counter;
    logic [BYTE_W-1:0]    r_type_lo;
    logic [STEP_W-1:0]    r_step;

    // frame being built
    t_pos                 r_fr_pos;
    logic [NUM_W-1:0]     r_fr_num;
    logic [DLEN_W-1:0]    r_fr_dlen;
    logic [CNT_W-1:0]     r_fr_base;
    logic                 r_fr_fin;
    logic [PAYLOAD_W-1:0] r_payload;

    // result register
    logic                 r_out_valid;
    logic [POS_W-1:0]     r_out_pos;
    logic [NUM_W-1:0]     r_out_num;
    logic [DLEN_W-1:0]    r_out_dlen;
    logic [PAYLOAD_W-1:0] r_out_payload;

    logic                 type_match;
    logic                 idx_ok;
    logic [CNT_W-1:0]     sub_len;
    logic                 fs_single;
    logic [CNT_W:0]       fs_next;
    logic                 fs_middle;
    logic [CNT_W-1:0]     fs_rem;
    logic [DLEN_W-1:0]    fs_final_dlen;

    assign type_match = ({r_rd_data, r_type_lo} == r_cfg_load_cmd_type);
    assign idx_ok     = (int'(r_idx) < MSG_BYTES);
    assign sub_len    = (int'(r_len) > MSG_BYTES) ? CNT_W'(MSG_BYTES) : CNT_W'(r_len);

    assign fs_single     = (r_total_length <= CNT_W'(FRAME_BYTES));
    assign fs_next       = (CNT_W+1)'(r_bytes_sent) + (CNT_W+1)'(FRAME_BYTES);
    assign fs_middle     = (fs_next < (CNT_W+1)'(r_total_length));
    assign fs_rem        = (r_total_length >= r_bytes_sent) ? (r_total_length - r_bytes_sent) : '0;
    assign fs_final_dlen = (fs_rem > CNT_W'(FRAME_BYTES)) ? DLEN_W'(FRAME_BYTES) : DLEN_W'(fs_rem);

    always_comb begin
        mem_addr  = ADDR_W'(r_idx);
        mem_we    = i_cmd.item_wr && idx_ok;
        mem_wdata = r_val;
        if (i_cmd.rd_lo) begin
            mem_addr = ADDR_W'(TYPE_LO_ADDR);
        end else if (i_cmd.rd_hi) begin
            mem_addr = ADDR_W'(TYPE_HI_ADDR);
        end else if (i_cmd.stamp_wr) begin
            mem_addr  = ADDR_W'(STAMP_ADDR) + ADDR_W'(r_step);
            mem_we    = 1'b1;
            mem_wdata = BYTE_W'(r_msg_counter >> (BYTE_W * r_step[STAMP_SEL_W-1:0]));
        end else if (i_cmd.gather) begin
            mem_addr = ADDR_W'(r_fr_base + CNT_W'(r_step));
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_addr];
    end

    // data registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_item) begin
            r_op  <= i_op;
            r_idx <= i_byte_index;
            r_val <= i_byte_value;
            r_len <= i_msg_length;
        end
        if (i_cmd.rd_hi) begin
            r_type_lo <= r_rd_data;
        end
        if (i_cmd.frame_setup) begin
            r_payload <= '0;
            if (fs_single) begin
                r_fr_pos  <= POS_SINGLE;
                r_fr_num  <= '0;
                r_fr_dlen <= DLEN_W'(r_total_length);
                r_fr_base <= '0;
                r_fr_fin  <= 1'b1;
            end else if (r_start_pending) begin
                r_fr_pos  <= POS_FIRST;
                r_fr_num  <= '0;
                r_fr_dlen <= DLEN_W'(FRAME_BYTES);
                r_fr_base <= '0;
                r_fr_fin  <= 1'b0;
            end else if (fs_middle) begin
                r_fr_pos  <= POS_MIDDLE;
                r_fr_num  <= r_seg_cnt + NUM_W'(1);
                r_fr_dlen <= DLEN_W'(FRAME_BYTES);
                r_fr_base <= r_bytes_sent;
                r_fr_fin  <= 1'b0;
            end else begin
                r_fr_pos  <= POS_FINAL;
                r_fr_num  <= r_seg_cnt + NUM_W'(1);
                r_fr_dlen <= fs_final_dlen;
                r_fr_base <= r_bytes_sent;
                r_fr_fin  <= 1'b1;
            end
        end else if (i_cmd.gather && r_step != '0) begin
            // read data is registered behind the address: step k delivers byte k-1
            for (int j = 0; j < FRAME_BYTES; j++) begin
                if (r_step == STEP_W'(j + 1)) begin
                    r_payload[BYTE_W*j +: BYTE_W] <=
                        (DLEN_W'(j) < r_fr_dlen) ? r_rd_data : '0;
                end
            end
        end
        if (i_cmd.out_load) begin
            r_out_pos     <= r_fr_pos;
            r_out_num     <= r_fr_num;
            r_out_dlen    <= r_fr_dlen;
            r_out_payload <= r_payload;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_load_cmd_type <= '0;
            r_cfg_retry_delay   <= DELAY_W'(RETRY_DELAY_RST);
            r_cfg_max_retries   <= RETRY_W'(MAX_RETRIES_RST);
            r_total_length      <= '0;
            r_bytes_sent        <= '0;
            r_seg_cnt           <= '0;
            r_start_pending     <= 1'b0;
            r_busy              <= 1'b0;
            r_retry_timer       <= '0;
            r_retry_count       <= '0;
            r_msg_counter       <= '0;
            r_step              <= '0;
            r_out_valid         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOAD_CMD_TYPE: r_cfg_load_cmd_type <= i_cfg_data[LOAD_CMD_W-1:0];
                    CFG_RETRY_DELAY:   r_cfg_retry_delay   <= i_cfg_data[DELAY_W-1:0];
                    CFG_MAX_RETRIES:   r_cfg_max_retries   <= i_cfg_data[RETRY_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (i_cmd.step_clr) begin
                r_step <= '0;
            end else if (i_cmd.step_inc) begin
                r_step <= r_step + STEP_W'(1);
            end

            if (i_cmd.tick && r_retry_timer != '0) begin
                r_retry_timer <= r_retry_timer - DELAY_W'(1);
                // timer expiring with no acknowledge while retries remain: resend from the start
                if (r_retry_timer == DELAY_W'(1) && r_retry_count < r_cfg_max_retries) begin
                    r_retry_count   <= r_retry_count + RETRY_W'(1);
                    r_start_pending <= 1'b1;
                    r_busy          <= 1'b1;
                end
            end

            if (i_cmd.ack) begin
                r_retry_timer <= '0;
            end

            if (i_cmd.submit_apply) begin
                if (type_match) begin
                    r_msg_counter <= r_msg_counter + MSG_CNT_W'(1);
                end
                r_total_length  <= sub_len;
                r_start_pending <= 1'b1;
                r_busy          <= 1'b1;
                r_retry_timer   <= '0;
                r_retry_count   <= '0;
            end

            if (i_cmd.finish_apply) begin
                if (type_match) begin
                    r_retry_timer <= r_cfg_retry_delay;
                end
                r_busy <= 1'b0;
            end

            if (i_cmd.frame_setup && !fs_single) begin
                if (r_start_pending) begin
                    r_seg_cnt       <= '0;
                    r_bytes_sent    <= CNT_W'(FRAME_BYTES);
                    r_start_pending <= 1'b0;
                end else if (fs_middle) begin
                    r_seg_cnt    <= r_seg_cnt + NUM_W'(1);
                    r_bytes_sent <= CNT_W'(fs_next);
                end else begin
                    r_seg_cnt <= r_seg_cnt + NUM_W'(1);
                end
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.op         = r_op;
    assign o_sts.busy       = r_busy;
    assign o_sts.type_match = type_match;
    assign o_sts.frame_fin  = r_fr_fin;
    assign o_sts.step       = r_step;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_seg_position = r_out_pos;
    assign o_seg_number   = r_out_num;
    assign o_data_length  = r_out_dlen;
    assign o_payload      = r_out_payload;

    `CMS_ASSERT_SAME(a_sent_below_total, r_busy && !r_start_pending, r_bytes_sent < r_total_length)
    `CMS_ASSERT_SAME(a_total_in_store, 1'b1, r_total_length <= CNT_W'(MSG_BYTES))
    `CMS_ASSERT_SAME(a_single_num_zero, r_out_valid && r_out_pos == POS_SINGLE, r_out_num == '0)
    `CMS_ASSERT_SAME(a_empty_payload, r_out_valid && r_out_dlen == '0, r_out_payload == '0)

endmodule

FILE: design/can_message_segmenter_with_retry_top.sv
// CAN message segmenter with acknowledge-timeout retry. Words are taken one at a
// time. A byte write, tick or acknowledge passes through a dispatch state before the
// next ready. A submit reads the message type twice from the single-port store and,
// when it matches, stamps the load-command counter into bytes 2 to 5, one byte write
// a cycle. A transmit slot reads the frame's 8 bytes through the one store port, with
// the read data registered behind the address; a frame that ends the message reads
// the message type again. A finished frame waits in an output register, and the
// next word is accepted meanwhile; only the next frame stalls until it is taken.
// Depends on cms_pkg, cms_if, cms_ctrl and cms_dpath.
module can_message_segmenter_with_retry_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cms_in_if.sink                         i_in,
    cms_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [cms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cms_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cms_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    cms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    cms_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_op           (i_in.op),
        .i_byte_index   (i_in.byte_index),
        .i_byte_value   (i_in.byte_value),
        .i_msg_length   (i_in.msg_length),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_seg_position (o_out.seg_position),
        .o_seg_number   (o_out.seg_number),
        .o_data_length  (o_out.data_length),
        .o_payload      (o_out.payload),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

endmodule
